// ----- rtl/modbus_rtu_request_framer_top_defines.svh -----
// assertion macros for the modbus rtu request framer
`ifndef MODBUS_RTU_REQUEST_FRAMER_TOP_DEFINES_SVH
`define MODBUS_RTU_REQUEST_FRAMER_TOP_DEFINES_SVH

// same-cycle implication, quiet during reset
`define MRF_ASSERT_IMP(label, cond, conseq, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (conseq)) \
      else $error(msg);

// next-cycle implication, quiet during reset
`define MRF_ASSERT_NXT(label, cond, conseq, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (conseq)) \
      else $error(msg);

`endif

// ----- rtl/mrf_pkg.sv -----
// types, constants and crc function shared by the modbus rtu request framer
package mrf_pkg;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 17;
   localparam int POS_W      = 4;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_CODE_READ  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CODE_WRITE = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CODE_BCAST = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ADDR_MIN   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_ADDR_MAX   = 3'd4;

   // reset values of the configuration registers
   localparam logic [7:0]  RST_CODE_READ  = 8'd3;
   localparam logic [7:0]  RST_CODE_WRITE = 8'd16;
   localparam logic [7:0]  RST_CODE_BCAST = 8'd0;
   localparam logic [15:0] RST_ADDR_MIN   = 16'd0;
   localparam logic [16:0] RST_ADDR_MAX   = 17'd65535;

   // input word kinds
   localparam logic CMD_HEADER = 1'b0;
   localparam logic CMD_DATA   = 1'b1;

   localparam logic [15:0] CRC_INIT      = 16'hFFFF;
   localparam logic [15:0] CRC_POLY      = 16'hA001;
   localparam logic [7:0]  FUNC_ERR_FLAG = 8'h10;

   // byte positions within a header word
   localparam logic [POS_W-1:0] POS_ID       = 4'd0;
   localparam logic [POS_W-1:0] POS_FUNC     = 4'd1;
   localparam logic [POS_W-1:0] POS_ADDR_HI  = 4'd2;
   localparam logic [POS_W-1:0] POS_ADDR_LO  = 4'd3;
   localparam logic [POS_W-1:0] POS_CNT_HI   = 4'd4;
   localparam logic [POS_W-1:0] POS_CNT_LO   = 4'd5;
   localparam logic [POS_W-1:0] POS_BYTE_CNT = 4'd6;
   localparam logic [POS_W-1:0] POS_SEVEN    = 4'd7;
   localparam logic [POS_W-1:0] POS_EIGHT    = 4'd8;

   // byte positions within a data word
   localparam logic [POS_W-1:0] POS_WORD_HI = 4'd0;
   localparam logic [POS_W-1:0] POS_WORD_LO = 4'd1;
   localparam logic [POS_W-1:0] POS_DCRC_LO = 4'd2;
   localparam logic [POS_W-1:0] POS_DCRC_HI = 4'd3;

   typedef struct packed {
      logic [7:0]  code_read;
      logic [7:0]  code_write;
      logic [7:0]  code_bcast;
      logic [15:0] addr_min;
      logic [16:0] addr_max;
   } cfg_type;

   typedef struct packed {
      logic        cmd;
      logic [7:0]  unit_id;
      logic [7:0]  fn_code;
      logic [15:0] start_addr;
      logic [6:0]  reg_count;
      logic [15:0] data_word;
   } item_type;

   typedef struct packed {
      logic        emit;
      logic [7:0]  tx_byte;
      logic        frame_end;
      logic        done;
      logic [POS_W-1:0] pos_next;
      logic [15:0] crc_next;
      logic [6:0]  words_next;
      logic        open_next;
   } step_type;

   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage

// ----- rtl/mrf_csr.sv -----
// configuration registers of the modbus rtu request framer
module mrf_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_we,
   input  logic [mrf_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [mrf_pkg::CSR_DATA_W-1:0] csr_wdata,
   output mrf_pkg::cfg_type               cfg
);
   import mrf_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_CODE_READ:  cfg_in.code_read  = csr_wdata[7:0];
            CSR_CODE_WRITE: cfg_in.code_write = csr_wdata[7:0];
            CSR_CODE_BCAST: cfg_in.code_bcast = csr_wdata[7:0];
            CSR_ADDR_MIN:   cfg_in.addr_min   = csr_wdata[15:0];
            CSR_ADDR_MAX:   cfg_in.addr_max   = csr_wdata[16:0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.code_read  <= RST_CODE_READ;
         cfg_ff.code_write <= RST_CODE_WRITE;
         cfg_ff.code_bcast <= RST_CODE_BCAST;
         cfg_ff.addr_min   <= RST_ADDR_MIN;
         cfg_ff.addr_max   <= RST_ADDR_MAX;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ----- rtl/mrf_emit.sv -----
// byte step logic: picks the next frame byte of the held word and updates the crc
module mrf_emit (
   input  mrf_pkg::cfg_type              cfg,
   input  mrf_pkg::item_type             item,
   input  logic [mrf_pkg::POS_W-1:0]     pos,
   input  logic [15:0]                   crc_acc,
   input  logic [6:0]                    words_left,
   input  logic                          write_open,
   output mrf_pkg::step_type             step
);
   import mrf_pkg::*;

   logic        is_bcast;
   logic        is_write;
   logic        is_read;
   logic        addr_ok;
   logic [7:0]  func_byte;
   logic [15:0] crc_base;
   logic        crc_fold;
   logic        crc_clear;
   logic [6:0]  words_dec;

   always_comb begin
      is_bcast  = (item.fn_code == cfg.code_bcast);
      is_write  = !is_bcast && (item.fn_code == cfg.code_write);
      is_read   = !is_bcast && !is_write && (item.fn_code == cfg.code_read);
      addr_ok   = (item.start_addr >= cfg.addr_min) &&
                  (({1'b0, item.start_addr} + {10'd0, item.reg_count}) <= cfg.addr_max);
      func_byte = addr_ok ? item.fn_code : (item.fn_code | FUNC_ERR_FLAG);
      words_dec = words_left - 7'd1;

      step            = '0;
      step.pos_next   = pos + 4'd1;
      step.words_next = words_left;
      step.open_next  = write_open;
      crc_base        = crc_acc;
      crc_fold        = 1'b0;
      crc_clear       = 1'b0;

      if (item.cmd == CMD_HEADER) begin
         // any header drops a frame that is still open
         if (pos == POS_ID) begin
            crc_base        = CRC_INIT;
            step.words_next = 7'd0;
            step.open_next  = 1'b0;
         end
         case (pos)
            POS_ID: begin
               if (is_bcast) begin
                  step.emit      = 1'b1;
                  step.tx_byte   = item.unit_id;
                  step.frame_end = 1'b1;
                  step.done      = 1'b1;
               end else if (is_write || is_read) begin
                  step.emit    = 1'b1;
                  step.tx_byte = item.unit_id;
                  crc_fold     = 1'b1;
               end else begin
                  step.done = 1'b1;
               end
            end
            POS_FUNC: begin
               step.emit    = 1'b1;
               step.tx_byte = func_byte;
               crc_fold     = 1'b1;
            end
            POS_ADDR_HI: begin
               step.emit    = 1'b1;
               step.tx_byte = item.start_addr[15:8];
               crc_fold     = 1'b1;
            end
            POS_ADDR_LO: begin
               step.emit    = 1'b1;
               step.tx_byte = item.start_addr[7:0];
               crc_fold     = 1'b1;
            end
            POS_CNT_HI: begin
               step.emit    = 1'b1;
               step.tx_byte = 8'd0;
               crc_fold     = 1'b1;
            end
            POS_CNT_LO: begin
               step.emit    = 1'b1;
               step.tx_byte = {1'b0, item.reg_count};
               crc_fold     = 1'b1;
            end
            POS_BYTE_CNT: begin
               step.emit = 1'b1;
               if (is_write) begin
                  step.tx_byte = {item.reg_count, 1'b0};
                  crc_fold     = 1'b1;
                  // non-empty write leaves the frame open for data words
                  if (item.reg_count != 7'd0) begin
                     step.done       = 1'b1;
                     step.words_next = item.reg_count;
                     step.open_next  = 1'b1;
                  end
               end else begin
                  step.tx_byte = crc_acc[7:0];
               end
            end
            POS_SEVEN: begin
               step.emit = 1'b1;
               if (is_write) begin
                  step.tx_byte = crc_acc[7:0];
               end else begin
                  step.tx_byte   = crc_acc[15:8];
                  step.frame_end = 1'b1;
                  step.done      = 1'b1;
                  crc_clear      = 1'b1;
               end
            end
            POS_EIGHT: begin
               step.emit      = 1'b1;
               step.tx_byte   = crc_acc[15:8];
               step.frame_end = 1'b1;
               step.done      = 1'b1;
               crc_clear      = 1'b1;
            end
            default: begin
               step.done = 1'b1;
            end
         endcase
      end else begin
         case (pos)
            POS_WORD_HI: begin
               if (!write_open) begin
                  step.done = 1'b1;
               end else begin
                  step.emit    = 1'b1;
                  step.tx_byte = item.data_word[15:8];
                  crc_fold     = 1'b1;
               end
            end
            POS_WORD_LO: begin
               step.emit       = 1'b1;
               step.tx_byte    = item.data_word[7:0];
               crc_fold        = 1'b1;
               step.words_next = words_dec;
               if (words_dec != 7'd0) begin
                  step.done = 1'b1;
               end
            end
            POS_DCRC_LO: begin
               step.emit    = 1'b1;
               step.tx_byte = crc_acc[7:0];
            end
            POS_DCRC_HI: begin
               step.emit      = 1'b1;
               step.tx_byte   = crc_acc[15:8];
               step.frame_end = 1'b1;
               step.done      = 1'b1;
               crc_clear      = 1'b1;
            end
            default: begin
               step.done = 1'b1;
            end
         endcase
      end

      if (crc_clear) begin
         step.crc_next   = CRC_INIT;
         step.words_next = 7'd0;
         step.open_next  = 1'b0;
      end else if (crc_fold) begin
         step.crc_next = crc_byte(crc_base, step.tx_byte);
      end else begin
         step.crc_next = crc_base;
      end

      if (step.done) begin
         step.pos_next = '0;
      end
   end

endmodule

// ----- rtl/modbus_rtu_request_framer_top.sv -----
// Modbus RTU request framer: turns header and write data words into a framed byte stream
// with a trailing reflected CRC-16. Bytes leave one per cycle from a single byte emitter
// while the result register is free or draining. Bytes per word: a read header 8, a write
// header 7 (or 9 when its count is zero), a data word 2 (4 when it closes the frame with
// its CRC), a broadcast header 1, and an unknown code or an unexpected data word none.
// The next word is taken in the cycle the current one yields its last byte, and a full
// result register does not stop a word from being taken into an empty input register.
// There is no clearing pass after reset.
module modbus_rtu_request_framer_top (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic                           req_cmd,
   input  logic [7:0]                     req_unit_id,
   input  logic [7:0]                     req_fn_code,
   input  logic [15:0]                    req_start_addr,
   input  logic [6:0]                     req_reg_count,
   input  logic [15:0]                    req_data_word,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [7:0]                     rsp_tx_byte,
   output logic                           rsp_frame_end,
   input  logic                           csr_we,
   input  logic [mrf_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [mrf_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import mrf_pkg::*;

   cfg_type    cfg;
   step_type   step;

   item_type   item_ff;
   item_type   item_in;
   logic       item_valid_ff;
   logic       item_valid_in;
   logic [POS_W-1:0] pos_ff;
   logic [POS_W-1:0] pos_in;
   logic [15:0] crc_ff;
   logic [15:0] crc_in;
   logic [6:0]  words_ff;
   logic [6:0]  words_in;
   logic        open_ff;
   logic        open_in;
   logic        rsp_valid_ff;
   logic        rsp_valid_in;
   logic [7:0]  tx_byte_ff;
   logic [7:0]  tx_byte_in;
   logic        frame_end_ff;
   logic        frame_end_in;

   logic step_go;
   logic req_fire;
   logic open_at_rest;
   logic end_step;
   logic frame_closed;

   mrf_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   mrf_emit u_emit (
      .cfg        (cfg),
      .item       (item_ff),
      .pos        (pos_ff),
      .crc_acc    (crc_ff),
      .words_left (words_ff),
      .write_open (open_ff),
      .step       (step)
   );

   // the emitter moves only when the result register is free or draining
   assign step_go   = item_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !item_valid_ff || (step_go && step.done);
   assign req_fire  = req_valid && req_ready;

   always_comb begin
      item_in       = item_ff;
      item_valid_in = item_valid_ff;
      pos_in        = pos_ff;
      crc_in        = crc_ff;
      words_in      = words_ff;
      open_in       = open_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      tx_byte_in    = tx_byte_ff;
      frame_end_in  = frame_end_ff;

      if (step_go) begin
         pos_in   = step.pos_next;
         crc_in   = step.crc_next;
         words_in = step.words_next;
         open_in  = step.open_next;
         if (step.done) begin
            item_valid_in = 1'b0;
         end
         if (step.emit) begin
            rsp_valid_in = 1'b1;
            tx_byte_in   = step.tx_byte;
            frame_end_in = step.frame_end;
         end
      end

      if (req_fire) begin
         item_valid_in        = 1'b1;
         item_in.cmd          = req_cmd;
         item_in.unit_id      = req_unit_id;
         item_in.fn_code      = req_fn_code;
         item_in.start_addr   = req_start_addr;
         item_in.reg_count    = req_reg_count;
         item_in.data_word    = req_data_word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         pos_ff        <= '0;
         crc_ff        <= CRC_INIT;
         words_ff      <= 7'd0;
         open_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         item_valid_ff <= item_valid_in;
         pos_ff        <= pos_in;
         crc_ff        <= crc_in;
         words_ff      <= words_in;
         open_ff       <= open_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff      <= item_in;
      tx_byte_ff   <= tx_byte_in;
      frame_end_ff <= frame_end_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_tx_byte   = tx_byte_ff;
   assign rsp_frame_end = frame_end_ff;

   // words run out before the closing crc bytes, so only check between words
   assign open_at_rest = open_ff && (pos_ff == '0);
   assign end_step     = step_go && step.emit && step.frame_end;
   assign frame_closed = (crc_ff == CRC_INIT) && !open_ff;

`include "modbus_rtu_request_framer_top_defines.svh"

   `MRF_ASSERT_IMP(a_open_has_words, open_at_rest, words_ff != 7'd0, "open frame has no words")
   `MRF_ASSERT_IMP(a_pos_needs_word, pos_ff != '0, item_valid_ff, "position set with no word")
   `MRF_ASSERT_NXT(a_end_clears_frame, end_step, frame_closed, "frame end left state behind")

endmodule
